// ----- src/sgsp_pkg.sv -----
package sgsp_pkg;

  // Sizes of the tables and fields
  localparam int SEG_W    = 10;
  localparam int NUM_SEG  = 1024;
  localparam int EDGE_W   = 12;
  localparam int NUM_EDGE = 4096;
  localparam int LEN_W    = 24;
  localparam int CNT_W    = 4;
  localparam int DIST_W   = 35;
  localparam int PLEN_W   = 11;
  localparam int ROUND_W  = 10;
  localparam int BASE_W   = LEN_W + 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 11;
  localparam int FUNC_W   = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_SEG  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_SUCC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RD_PATH = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_LIMIT = 1'b1;
  localparam logic [PLEN_W-1:0]    SEG_COUNT_RST   = 11'd1024;
  localparam logic [ROUND_W-1:0]   ROUND_LIMIT_RST = 10'd1000;

  // Sequencer steps
  typedef logic [4:0] step_t;
  localparam step_t ST_IDLE    = 5'd0;
  localparam step_t ST_PREAD   = 5'd1;
  localparam step_t ST_QINFO   = 5'd2;
  localparam step_t ST_DIR_RD  = 5'd3;
  localparam step_t ST_DIR_CMP = 5'd4;
  localparam step_t ST_CLR     = 5'd5;
  localparam step_t ST_INI_RD  = 5'd6;
  localparam step_t ST_INI_S   = 5'd7;
  localparam step_t ST_INI_UPD = 5'd8;
  localparam step_t ST_RND     = 5'd9;
  localparam step_t ST_SC_RD   = 5'd10;
  localparam step_t ST_SC_V    = 5'd11;
  localparam step_t ST_SC_N    = 5'd12;
  localparam step_t ST_SET     = 5'd13;
  localparam step_t ST_SET2    = 5'd14;
  localparam step_t ST_RL_RD   = 5'd15;
  localparam step_t ST_RL_S    = 5'd16;
  localparam step_t ST_RL_N    = 5'd17;
  localparam step_t ST_PATH    = 5'd18;
  localparam step_t ST_W1      = 5'd19;
  localparam step_t ST_W1R     = 5'd20;
  localparam step_t ST_W2      = 5'd21;
  localparam step_t ST_W2R     = 5'd22;

  typedef struct packed {
    step_t step;
    logic  accept;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic same_seg;
    logic deg_end;
    logic dir_hit;
    logic clr_end;
    logic rnd_end;
    logic scan_end;
    logic found;
    logic end_settled;
    logic walk_end;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SEG_W-1:0]  seg_index;
    logic [LEN_W-1:0]  seg_length;
    logic [EDGE_W-1:0] succ_base;
    logic [CNT_W-1:0]  succ_count;
    logic [EDGE_W-1:0] succ_addr;
    logic [SEG_W-1:0]  succ_seg;
    logic [SEG_W-1:0]  from_seg;
    logic [LEN_W-1:0]  from_pos;
    logic [SEG_W-1:0]  to_seg;
    logic [LEN_W-1:0]  to_pos;
    logic [SEG_W-1:0]  path_pos;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic [PLEN_W-1:0] path_length;
    logic [SEG_W-1:0]  path_seg;
  } rsp_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [EDGE_W-1:0] base;
    logic [CNT_W-1:0]  cnt;
  } seg_info_t;

  typedef struct packed {
    logic              visited;
    logic              settled;
    logic [SEG_W-1:0]  pred;
    logic [DIST_W-1:0] cost;
  } node_t;

  // Clamp a signed distance into the unsigned result range.
  function automatic logic [DIST_W-1:0] clamp_dist(input logic signed [DIST_W+1:0] d);
    logic [DIST_W-1:0] r;
    if (d < 0) begin
      r = '0;
    end else if (d > $signed({2'b00, DIST_MAX})) begin
      r = DIST_MAX;
    end else begin
      r = d[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/sgsp_req_if.sv -----
interface sgsp_req_if;
  import sgsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SEG_W-1:0]    seg_index;
  logic [LEN_W-1:0]    seg_length;
  logic [EDGE_W-1:0]   succ_base;
  logic [CNT_W-1:0]    succ_count;
  logic [EDGE_W-1:0]   succ_addr;
  logic [SEG_W-1:0]    succ_seg;
  logic [SEG_W-1:0]    from_seg;
  logic [LEN_W-1:0]    from_pos;
  logic [SEG_W-1:0]    to_seg;
  logic [LEN_W-1:0]    to_pos;
  logic [SEG_W-1:0]    path_pos;

  modport source (output valid, func, seg_index, seg_length, succ_base, succ_count,
                  succ_addr, succ_seg, from_seg, from_pos, to_seg, to_pos, path_pos,
                  input ready);
  modport sink (input valid, func, seg_index, seg_length, succ_base, succ_count,
                succ_addr, succ_seg, from_seg, from_pos, to_seg, to_pos, path_pos,
                output ready);
endinterface

// ----- src/sgsp_rsp_if.sv -----
interface sgsp_rsp_if;
  import sgsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              reachable;
  logic [PLEN_W-1:0] path_length;
  logic [SEG_W-1:0]  path_seg;

  modport source (output valid, distance, reachable, path_length, path_seg, input ready);
  modport sink (input valid, distance, reachable, path_length, path_seg, output ready);
endinterface

// ----- src/sgsp_ctrl.sv -----
module sgsp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sgsp_pkg::stat_t stat,
  output sgsp_pkg::cmd_t  cmd
);
  import sgsp_pkg::*;

  step_t state;
  step_t state_next;
  logic  accept;

  // Items are taken only between operations and when the result register will be free.
  assign req_ready  = (state == ST_IDLE) && stat.out_free;
  assign accept     = req_valid && req_ready;
  assign cmd.step   = state;
  assign cmd.accept = accept;

  // Step sequencing of table writes, path reads and the search.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (stat.func == FUNC_QUERY) begin
            state_next = ST_QINFO;
          end else if (stat.func == FUNC_RD_PATH) begin
            state_next = ST_PREAD;
          end
        end
      end
      ST_PREAD:   state_next = ST_IDLE;
      ST_QINFO:   state_next = stat.same_seg ? ST_IDLE : ST_DIR_RD;
      ST_DIR_RD:  state_next = stat.deg_end ? ST_CLR : ST_DIR_CMP;
      ST_DIR_CMP: state_next = stat.dir_hit ? ST_IDLE : ST_DIR_RD;
      ST_CLR:     state_next = stat.clr_end ? ST_INI_RD : ST_CLR;
      ST_INI_RD:  state_next = stat.deg_end ? ST_RND : ST_INI_S;
      ST_INI_S:   state_next = ST_INI_UPD;
      ST_INI_UPD: state_next = ST_INI_RD;
      ST_RND:     state_next = stat.rnd_end ? ST_PATH : ST_SC_RD;
      ST_SC_RD: begin
        if (stat.scan_end) begin
          state_next = stat.found ? ST_SET : ST_PATH;
        end else begin
          state_next = ST_SC_V;
        end
      end
      ST_SC_V:    state_next = ST_SC_N;
      ST_SC_N:    state_next = ST_SC_RD;
      ST_SET:     state_next = ST_SET2;
      ST_SET2:    state_next = ST_RL_RD;
      ST_RL_RD:   state_next = stat.deg_end ? ST_RND : ST_RL_S;
      ST_RL_S:    state_next = ST_RL_N;
      ST_RL_N:    state_next = ST_RL_RD;
      ST_PATH:    state_next = stat.end_settled ? ST_W1 : ST_IDLE;
      ST_W1:      state_next = stat.walk_end ? ST_W2 : ST_W1R;
      ST_W1R:     state_next = ST_W1;
      ST_W2:      state_next = stat.walk_end ? ST_IDLE : ST_W2R;
      ST_W2R:     state_next = ST_W2;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/sgsp_datapath.sv -----
module sgsp_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sgsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgsp_pkg::CFG_W-1:0]     cfg_data,
  input  sgsp_pkg::req_t                 req,
  input  logic                           rsp_ready,
  input  sgsp_pkg::cmd_t                 cmd,
  output sgsp_pkg::stat_t                stat,
  output sgsp_pkg::rsp_t                 rsp,
  output logic                           rsp_valid
);
  import sgsp_pkg::*;

  // Memories
  seg_info_t         seg_mem   [NUM_SEG];
  logic [SEG_W-1:0]  succ_mem  [NUM_EDGE];
  node_t             node_mem  [NUM_SEG];
  logic [SEG_W-1:0]  visit_mem [NUM_SEG];
  logic [SEG_W-1:0]  path_mem  [NUM_SEG];

  seg_info_t         seg_rd;
  logic [SEG_W-1:0]  succ_rd;
  node_t             node_rd;
  logic [SEG_W-1:0]  visit_rd;
  logic [SEG_W-1:0]  path_rd;

  // Configuration and query registers
  logic [PLEN_W-1:0]        seg_count;
  logic [ROUND_W-1:0]       round_limit;
  logic [SEG_W-1:0]         qa;
  logic [SEG_W-1:0]         qb;
  logic [LEN_W-1:0]         fpos;
  logic [LEN_W-1:0]         tpos;
  logic [SEG_W-1:0]         ppos;
  logic [PLEN_W-1:0]        path_count;
  logic signed [BASE_W-1:0] base_d;

  // Search registers
  logic [CNT_W-1:0]   deg;
  logic [CNT_W-1:0]   en;
  logic [EDGE_W-1:0]  sbase;
  logic [ROUND_W-1:0] rounds;
  logic [ROUND_W-1:0] k;
  logic [PLEN_W-1:0]  idx;
  logic [PLEN_W-1:0]  vc;
  logic [SEG_W-1:0]   sreg;
  logic [SEG_W-1:0]   vreg;
  logic               found;
  logic [SEG_W-1:0]   best;
  logic [DIST_W-1:0]  bcost;
  logic [SEG_W-1:0]   bpred;
  logic [DIST_W-1:0]  cost_b;
  logic               end_settled;
  logic [DIST_W-1:0]  cand;
  logic [SEG_W-1:0]   last;
  logic [PLEN_W-1:0]  plen;
  logic [SEG_W-1:0]   first;

  // Memory ports
  logic [SEG_W-1:0]  seg_raddr;
  logic [EDGE_W-1:0] succ_raddr;
  logic [SEG_W-1:0]  node_raddr;
  logic              node_we;
  logic [SEG_W-1:0]  node_waddr;
  node_t             node_wdata;
  logic              visit_we;
  logic              path_we;
  logic [SEG_W-1:0]  path_waddr;
  logic [SEG_W-1:0]  path_wdata;
  logic [PLEN_W-1:0] pidx;

  // Datapath arithmetic
  logic                     acc_wr_seg;
  logic                     acc_wr_succ;
  logic                     acc_query;
  logic                     node_upd;
  logic                     node_fresh;
  logic                     walk_end;
  logic [PLEN_W-1:0]        r0;
  logic [DIST_W:0]          cand_sum;
  logic [LEN_W:0]           same_dist;
  logic signed [BASE_W-1:0] base_calc;
  logic signed [DIST_W+1:0] dist_sum;
  logic                     res_load;
  rsp_t                     res_next;

  assign acc_wr_seg  = cmd.accept && (req.func == FUNC_WR_SEG);
  assign acc_wr_succ = cmd.accept && (req.func == FUNC_WR_SUCC);
  assign acc_query   = cmd.accept && (req.func == FUNC_QUERY);

  assign node_fresh = !node_rd.visited;
  assign node_upd   = !node_rd.settled && (node_fresh || (cand < node_rd.cost));
  assign walk_end   = (last == qa) ||
                      ((cmd.step == ST_W1) ? (idx == PLEN_W'(NUM_SEG)) : (idx == plen));
  assign r0         = (seg_count > PLEN_W'(1)) ? (seg_count - PLEN_W'(1)) : '0;
  assign cand_sum   = {1'b0, bcost} + (DIST_W+1)'(seg_rd.len);
  assign same_dist  = (tpos >= fpos) ? ({1'b0, tpos} - {1'b0, fpos}) : {fpos - tpos, 1'b0};
  assign base_calc  = $signed({3'b000, seg_rd.len}) - $signed({3'b000, fpos})
                      + $signed({3'b000, tpos});
  assign dist_sum   = {{(DIST_W+2-BASE_W){base_d[BASE_W-1]}}, base_d}
                      + $signed({2'b00, cost_b});
  assign pidx       = plen - PLEN_W'(1) - idx;

  // Status toward the sequencer
  always_comb begin
    stat.func        = req.func;
    stat.same_seg    = (qa == qb);
    stat.deg_end     = (en == deg);
    stat.dir_hit     = (succ_rd == qb);
    stat.clr_end     = (idx == PLEN_W'(NUM_SEG - 1));
    stat.rnd_end     = (k == rounds) || end_settled;
    stat.scan_end    = (idx == vc);
    stat.found       = found;
    stat.end_settled = end_settled;
    stat.walk_end    = walk_end;
    stat.out_free    = !rsp_valid || rsp_ready;
  end

  // Read address selection
  assign seg_raddr  = (cmd.step == ST_SET) ? best : req.from_seg;
  assign succ_raddr = sbase + EDGE_W'(en);
  always_comb begin
    unique case (cmd.step)
      ST_INI_S, ST_RL_S: node_raddr = succ_rd;
      ST_SC_V:           node_raddr = visit_rd;
      default:           node_raddr = last;
    endcase
  end

  // Node state write: clearing pass, seeding, settling and relaxing
  always_comb begin
    node_we    = 1'b0;
    node_waddr = idx[SEG_W-1:0];
    node_wdata = '{visited: 1'b0, settled: 1'b0, pred: qa, cost: '0};
    unique case (cmd.step)
      ST_CLR: begin
        node_we = 1'b1;
      end
      ST_INI_UPD: begin
        node_we            = node_fresh;
        node_waddr         = sreg;
        node_wdata.visited = 1'b1;
      end
      ST_SET: begin
        node_we    = 1'b1;
        node_waddr = best;
        node_wdata = '{visited: 1'b1, settled: 1'b1, pred: bpred, cost: bcost};
      end
      ST_RL_N: begin
        node_we            = 1'b1;
        node_waddr         = sreg;
        node_wdata.visited = 1'b1;
        node_wdata.settled = node_rd.settled;
        node_wdata.pred    = node_upd ? best : node_rd.pred;
        node_wdata.cost    = node_upd ? cand : node_rd.cost;
      end
      default: begin
        node_we = 1'b0;
      end
    endcase
  end

  assign visit_we = ((cmd.step == ST_INI_UPD) || (cmd.step == ST_RL_N)) && node_fresh &&
                    (vc < PLEN_W'(NUM_SEG));

  // Path store writes: one entry for a direct hop, reversed walk otherwise
  always_comb begin
    path_we    = 1'b0;
    path_waddr = pidx[SEG_W-1:0];
    path_wdata = last;
    if ((cmd.step == ST_DIR_CMP) && stat.dir_hit) begin
      path_we    = 1'b1;
      path_waddr = '0;
      path_wdata = qb;
    end else if ((cmd.step == ST_W2) && !walk_end) begin
      path_we = 1'b1;
    end
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk) begin
    if (acc_wr_seg) begin
      seg_mem[req.seg_index] <= '{len: req.seg_length, base: req.succ_base,
                                  cnt: req.succ_count};
    end
    seg_rd <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_wr_succ) begin
      succ_mem[req.succ_addr] <= req.succ_seg;
    end
    succ_rd <= succ_mem[succ_raddr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (visit_we) begin
      visit_mem[vc[SEG_W-1:0]] <= sreg;
    end
    visit_rd <= visit_mem[idx[SEG_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    path_rd <= path_mem[req.path_pos];
  end

  // Result selection
  always_comb begin
    res_load = 1'b0;
    res_next = '0;
    unique case (cmd.step)
      ST_IDLE: begin
        res_load = acc_wr_seg || acc_wr_succ;
      end
      ST_PREAD: begin
        res_load             = 1'b1;
        res_next.path_length = path_count;
        res_next.path_seg    = (PLEN_W'(ppos) < path_count) ? path_rd : '0;
      end
      ST_QINFO: begin
        res_load           = stat.same_seg;
        res_next.distance  = DIST_W'(same_dist);
        res_next.reachable = 1'b1;
      end
      ST_DIR_CMP: begin
        res_load             = stat.dir_hit;
        res_next.distance    = clamp_dist({{(DIST_W+2-BASE_W){base_d[BASE_W-1]}}, base_d});
        res_next.reachable   = 1'b1;
        res_next.path_length = PLEN_W'(1);
        res_next.path_seg    = qb;
      end
      ST_PATH: begin
        res_load = !end_settled;
      end
      ST_W2: begin
        res_load             = walk_end;
        res_next.distance    = clamp_dist(dist_sum);
        res_next.reachable   = 1'b1;
        res_next.path_length = plen;
        res_next.path_seg    = first;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Output register, configuration registers and stored path length
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid   <= 1'b0;
      path_count  <= '0;
      seg_count   <= SEG_COUNT_RST;
      round_limit <= ROUND_LIMIT_RST;
    end else begin
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (acc_query) begin
        path_count <= '0;
      end else if ((cmd.step == ST_DIR_CMP) && stat.dir_hit) begin
        path_count <= PLEN_W'(1);
      end else if ((cmd.step == ST_W2) && walk_end) begin
        path_count <= plen;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SEG_COUNT) begin
          seg_count <= cfg_data;
        end else if (cfg_index == CFG_ROUND_LIMIT) begin
          round_limit <= cfg_data[ROUND_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res_next;
    end
  end

  // Working registers of the query and search
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      ST_IDLE: begin
        if (cmd.accept) begin
          qa   <= req.from_seg;
          qb   <= req.to_seg;
          fpos <= req.from_pos;
          tpos <= req.to_pos;
          ppos <= req.path_pos;
        end
      end
      ST_QINFO: begin
        base_d <= base_calc;
        deg    <= seg_rd.cnt;
        sbase  <= seg_rd.base;
        en     <= '0;
        idx    <= '0;
        rounds <= (r0 > PLEN_W'(round_limit)) ? round_limit : r0[ROUND_W-1:0];
      end
      ST_DIR_RD, ST_INI_RD: begin
        if (!stat.deg_end) begin
          en <= en + CNT_W'(1);
        end
      end
      ST_RL_RD: begin
        if (!stat.deg_end) begin
          en <= en + CNT_W'(1);
        end else begin
          k <= k + ROUND_W'(1);
        end
      end
      ST_CLR: begin
        if (stat.clr_end) begin
          idx         <= '0;
          en          <= '0;
          vc          <= '0;
          k           <= '0;
          end_settled <= 1'b0;
        end else begin
          idx <= idx + PLEN_W'(1);
        end
      end
      ST_INI_S, ST_RL_S: begin
        sreg <= succ_rd;
      end
      ST_INI_UPD, ST_RL_N: begin
        if (visit_we) begin
          vc <= vc + PLEN_W'(1);
        end
      end
      ST_RND: begin
        idx   <= '0;
        found <= 1'b0;
      end
      ST_SC_V: begin
        vreg <= visit_rd;
      end
      ST_SC_N: begin
        // First open entry with the strictly lowest cost wins.
        if (!node_rd.settled && (!found || (node_rd.cost < bcost))) begin
          found <= 1'b1;
          best  <= vreg;
          bcost <= node_rd.cost;
          bpred <= node_rd.pred;
        end
        idx <= idx + PLEN_W'(1);
      end
      ST_SET: begin
        if (best == qb) begin
          end_settled <= 1'b1;
          cost_b      <= bcost;
        end
      end
      ST_SET2: begin
        cand  <= cand_sum[DIST_W] ? DIST_MAX : cand_sum[DIST_W-1:0];
        deg   <= seg_rd.cnt;
        sbase <= seg_rd.base;
        en    <= '0;
      end
      ST_PATH: begin
        last <= qb;
        idx  <= '0;
      end
      ST_W1: begin
        if (walk_end) begin
          plen <= idx;
          last <= qb;
          idx  <= '0;
        end else begin
          idx <= idx + PLEN_W'(1);
        end
      end
      ST_W1R, ST_W2R: begin
        last <= node_rd.pred;
      end
      ST_W2: begin
        if (!walk_end) begin
          idx   <= idx + PLEN_W'(1);
          first <= last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/segment_graph_shortest_path_unit.sv -----
// Table writes are handled in the idle step; a path read goes through its own read step.
// A query on one segment is answered without a search; a direct hop tests each successor.
// A search first clears the 1024-entry node state memory, then each round scans the visited
// list with read, visit and next steps per entry and relaxes with read, store and next steps
// per successor, and the path walk counts, then stores; one item is worked on at a time.
// Synchronous reset clears the sequencer, result valid, path count and configuration.
module segment_graph_shortest_path_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sgsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgsp_pkg::CFG_W-1:0]     cfg_data,
  sgsp_req_if.sink                       req,
  sgsp_rsp_if.source                     rsp
);
  import sgsp_pkg::*;

  req_t  req_pl;
  rsp_t  rsp_pl;
  cmd_t  cmd;
  stat_t stat;
  logic  rsp_valid;
  logic  req_ready;

  // Gather the item fields into one payload.
  always_comb begin
    req_pl.func       = req.func;
    req_pl.seg_index  = req.seg_index;
    req_pl.seg_length = req.seg_length;
    req_pl.succ_base  = req.succ_base;
    req_pl.succ_count = req.succ_count;
    req_pl.succ_addr  = req.succ_addr;
    req_pl.succ_seg   = req.succ_seg;
    req_pl.from_seg   = req.from_seg;
    req_pl.from_pos   = req.from_pos;
    req_pl.to_seg     = req.to_seg;
    req_pl.to_pos     = req.to_pos;
    req_pl.path_pos   = req.path_pos;
  end

  assign req.ready       = req_ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.distance    = rsp_pl.distance;
  assign rsp.reachable   = rsp_pl.reachable;
  assign rsp.path_length = rsp_pl.path_length;
  assign rsp.path_seg    = rsp_pl.path_seg;

  sgsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sgsp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_pl),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp_pl),
    .rsp_valid (rsp_valid)
  );

endmodule
